[hdl/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

[hdl/gha_pkg.sv]
package gha_pkg;

  localparam int ENTITY_COUNT_DEF = 4096;
  localparam int INDEX_WIDTH_DEF  = 12;
  localparam int GEN_WIDTH_DEF    = 8;
  localparam int REQ_WIDTH        = 2;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_CHECK   = 2'd2
  } req_t;

endpackage

[hdl/generational_handle_allocator.sv]
// Channel | Handshake           | Payload
// in      | in_valid, in_stall   | req_type, entity_id, passport
// out     | out_valid, out_stall | entity_index, ok, live_count
//
// An item is accepted in ST_IDLE, and the edge that accepts it also reads the link and
// generation memories; the edge that leaves ST_WORK updates them and loads the result
// register. The synchronous memory read must follow the previous item's write-back, so
// in_stall stays high until the previous item has left ST_WORK.
// After reset a clearing pass over all ENTITY_COUNT entries (4096 by default) rebuilds the
// free list, with in_stall high.
// An item is accepted while the previous result still waits; it then holds in
// ST_WORK until out_stall drops.
`include "assert_macros.svh"

module generational_handle_allocator #(
  parameter int ENTITY_COUNT = gha_pkg::ENTITY_COUNT_DEF,
  parameter int INDEX_WIDTH  = gha_pkg::INDEX_WIDTH_DEF,
  parameter int GEN_WIDTH    = gha_pkg::GEN_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gha_pkg::REQ_WIDTH-1:0]      req_type,
  input  logic [INDEX_WIDTH-1:0]             entity_id,
  input  logic [INDEX_WIDTH+GEN_WIDTH-1:0]   passport,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [INDEX_WIDTH-1:0]             entity_index,
  output logic                               ok,
  output logic [INDEX_WIDTH:0]               live_count
);

  import gha_pkg::*;

  localparam int ADDR_W = $clog2(ENTITY_COUNT);
  localparam int LINK_W = INDEX_WIDTH + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WORK} state_t;

  state_t                          state;
  logic [ADDR_W-1:0]               clear_idx;
  logic [LINK_W-1:0]               free_head;
  logic [LINK_W-1:0]               used_count;

  logic [REQ_WIDTH-1:0]            req_q;
  logic [INDEX_WIDTH-1:0]          id_q;
  logic [INDEX_WIDTH+GEN_WIDTH-1:0] pp_q;

  logic [LINK_W-1:0]               link_mem [ENTITY_COUNT];
  logic [GEN_WIDTH-1:0]            gen_mem  [ENTITY_COUNT];
  logic [LINK_W-1:0]               link_rd;
  logic [GEN_WIDTH-1:0]            gen_rd;

  logic                            accept;
  logic                            done;
  logic [ADDR_W-1:0]               rd_addr;

  logic                            res_ok;
  logic [INDEX_WIDTH-1:0]          res_index;
  logic [LINK_W-1:0]               free_head_next;
  logic [LINK_W-1:0]               used_count_next;

  logic                            link_we;
  logic [ADDR_W-1:0]               link_wa;
  logic [LINK_W-1:0]               link_wd;
  logic                            gen_we;
  logic [ADDR_W-1:0]               gen_wa;
  logic [GEN_WIDTH-1:0]            gen_wd;

  logic [INDEX_WIDTH-1:0]          chk_index;
  logic [GEN_WIDTH-1:0]            chk_gen;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state == ST_WORK) && (!out_valid || !out_stall);

  assign chk_index = pp_q[INDEX_WIDTH-1:0];
  assign chk_gen   = pp_q[INDEX_WIDTH +: GEN_WIDTH];

  // The read address is taken from the ports so the data is registered at the edge that accepts the item.
  always_comb begin
    case (req_type)
      REQ_CREATE:  rd_addr = free_head[ADDR_W-1:0];
      REQ_DESTROY: rd_addr = entity_id[ADDR_W-1:0];
      default:     rd_addr = passport[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    res_ok          = 1'b0;
    res_index       = '0;
    free_head_next  = free_head;
    used_count_next = used_count;
    link_we         = 1'b0;
    link_wa         = clear_idx;
    link_wd         = '0;
    gen_we          = 1'b0;
    gen_wa          = clear_idx;
    gen_wd          = '0;
    if (state == ST_CLEAR) begin
      // Entry 0 is the null entity and links to itself.
      link_we = 1'b1;
      link_wd = (clear_idx == '0) ? '0 : LINK_W'(clear_idx) + LINK_W'(1);
      gen_we  = 1'b1;
    end else begin
      case (req_q)
        REQ_CREATE: begin
          if (free_head < LINK_W'(ENTITY_COUNT)) begin
            res_ok          = 1'b1;
            res_index       = free_head[INDEX_WIDTH-1:0];
            free_head_next  = link_rd;
            used_count_next = used_count + LINK_W'(1);
            link_we         = done;
            link_wa         = free_head[ADDR_W-1:0];
            link_wd         = free_head;
          end
        end
        REQ_DESTROY: begin
          res_index = id_q;
          // Apart from the null entry 0, a live entry is the only one whose link points back at itself.
          if (id_q != '0 && {1'b0, id_q} < LINK_W'(ENTITY_COUNT) &&
              link_rd == {1'b0, id_q}) begin
            res_ok          = 1'b1;
            free_head_next  = {1'b0, id_q};
            used_count_next = used_count - LINK_W'(1);
            link_we         = done;
            link_wa         = id_q[ADDR_W-1:0];
            link_wd         = free_head;
            gen_we          = done;
            gen_wa          = id_q[ADDR_W-1:0];
            gen_wd          = gen_rd + GEN_WIDTH'(1);
          end
        end
        REQ_CHECK: begin
          res_index = chk_index;
          res_ok    = ({1'b0, chk_index} < LINK_W'(ENTITY_COUNT)) && (gen_rd == chk_gen);
        end
        default: begin
          res_index = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (accept) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (accept) begin
      gen_rd <= gen_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_idx  <= '0;
      free_head  <= LINK_W'(1);
      used_count <= LINK_W'(1);
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clear_idx <= clear_idx + ADDR_W'(1);
          if (clear_idx == ADDR_W'(ENTITY_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_q <= req_type;
            id_q  <= entity_id;
            pp_q  <= passport;
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (done) begin
            free_head <= free_head_next;
            used_count <= used_count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (done) begin
        out_valid    <= 1'b1;
        entity_index <= res_index;
        ok           <= res_ok;
        live_count   <= used_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The free list is empty exactly when every index is live.
  `ASSERT_IMPLIES(a_head_matches_count, clk, rst, 1'b1, (free_head >= LINK_W'(ENTITY_COUNT)) == (used_count == LINK_W'(ENTITY_COUNT)))
  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, used_count != '0 && used_count <= LINK_W'(ENTITY_COUNT))
  `ASSERT_NEXT(a_create_counts, clk, rst, done && req_q == REQ_CREATE && res_ok, used_count == $past(used_count) + LINK_W'(1))
  `ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst, state == ST_CLEAR, !accept && !done)

endmodule

[bench/allocator_checker.sv]
`timescale 1ns / 100ps

module allocator_checker (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 in_valid,
  input  logic                                                 in_stall,
  input  logic [gha_pkg::REQ_WIDTH-1:0]                        req_type,
  input  logic [gha_pkg::INDEX_WIDTH_DEF-1:0]                  entity_id,
  input  logic [gha_pkg::INDEX_WIDTH_DEF+gha_pkg::GEN_WIDTH_DEF-1:0] passport,
  input  logic                                                 out_valid,
  input  logic                                                 out_stall,
  input  logic [gha_pkg::INDEX_WIDTH_DEF-1:0]                  entity_index,
  input  logic                                                 ok,
  input  logic [gha_pkg::INDEX_WIDTH_DEF:0]                    live_count,
  output int                                                   mismatches,
  output int                                                   pending
);

  import gha_pkg::*;

  localparam int NUM       = ENTITY_COUNT_DEF;
  localparam int IW        = INDEX_WIDTH_DEF;
  localparam int GW        = GEN_WIDTH_DEF;
  localparam int LW        = IW + 1;
  localparam int EXP_DEPTH = 8;
  localparam int EXP_AW    = 3;

  typedef struct packed {
    logic [IW-1:0] index;
    logic          hit;
    logic [IW:0]   live;
  } alloc_result_t;

  // A live entry links to itself; a free one links to the next free index.
  logic [IW:0]   link_mem [NUM];
  logic [GW-1:0] gen_mem  [NUM];
  logic [IW:0]   head;
  logic [IW:0]   used;

  // Expected results in order, as a small ring buffer.
  alloc_result_t     expected_mem [EXP_DEPTH];
  logic [EXP_AW-1:0] exp_wr;
  logic [EXP_AW-1:0] exp_rd;
  int                exp_count;

  function automatic logic is_live(logic [IW-1:0] idx);
    return idx != '0 && link_mem[idx] == {1'b0, idx};
  endfunction

  function automatic logic [GW-1:0] generation_of(logic [IW-1:0] idx);
    return gen_mem[idx];
  endfunction

  function automatic alloc_result_t allocate_or_release(logic [REQ_WIDTH-1:0] req,
                                                        logic [IW-1:0] id,
                                                        logic [IW+GW-1:0] pp);
    alloc_result_t r;
    logic [IW-1:0] pidx;
    logic [GW-1:0] pgen;
    r = '0;
    case (req)
      REQ_CREATE: begin
        if (head < LW'(NUM)) begin
          r.index = head[IW-1:0];
          head = link_mem[r.index];
          link_mem[r.index] = {1'b0, r.index};
          used = used + LW'(1);
          r.hit = 1'b1;
        end
      end
      REQ_DESTROY: begin
        r.index = id;
        if (is_live(id)) begin
          link_mem[id] = head;
          gen_mem[id] = gen_mem[id] + GW'(1);
          head = {1'b0, id};
          used = used - LW'(1);
          r.hit = 1'b1;
        end
      end
      REQ_CHECK: begin
        pidx = pp[IW-1:0];
        pgen = pp[IW +: GW];
        r.index = pidx;
        r.hit = (gen_mem[pidx] == pgen);
      end
      default: ;
    endcase
    r.live = used;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM; i++) begin
        link_mem[i] = LW'(i + 1);
        gen_mem[i] = '0;
      end
      link_mem[0] = '0;
      head = LW'(1);
      used = LW'(1);
      exp_wr = '0;
      exp_rd = '0;
      exp_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_count == 0) begin
          report_mismatch("result item with no request outstanding", 0, 32'(entity_index));
        end else begin
          want = expected_mem[exp_rd];
          exp_rd = exp_rd + EXP_AW'(1);
          exp_count--;
          if (entity_index !== want.index)
            report_mismatch("entity_index", 32'(want.index), 32'(entity_index));
          if (ok !== want.hit)
            report_mismatch("ok", 32'(want.hit), 32'(ok));
          if (live_count !== want.live)
            report_mismatch("live_count", 32'(want.live), 32'(live_count));
        end
      end
      if (in_valid && !in_stall) begin
        if (exp_count == EXP_DEPTH) begin
          report_mismatch("items outstanding", EXP_DEPTH - 1, exp_count);
        end else begin
          expected_mem[exp_wr] = allocate_or_release(req_type, entity_id, passport);
          exp_wr = exp_wr + EXP_AW'(1);
          exp_count++;
        end
      end
    end
    pending = exp_count;
  end

endmodule

[bench/tb_generational_handle_allocator.sv]
`timescale 1ns / 100ps

module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int NUM = ENTITY_COUNT_DEF;
  localparam int IW  = INDEX_WIDTH_DEF;
  localparam int GW  = GEN_WIDTH_DEF;
  localparam int PW  = IW + GW;
  localparam logic [REQ_WIDTH-1:0] REQ_UNKNOWN = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_WIDTH-1:0] req_type;
  logic [IW-1:0]        entity_id;
  logic [PW-1:0]        passport;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IW-1:0]        entity_index;
  logic                 ok;
  logic [IW:0]          live_count;
  int                   mismatches;
  int                   pending;
  int unsigned          gap_pct = 0;
  int unsigned          stall_pct = 0;

  always #5 clk = ~clk;

  generational_handle_allocator dut (
    .clk, .rst, .in_valid, .in_stall, .req_type, .entity_id, .passport,
    .out_valid, .out_stall, .entity_index, .ok, .live_count
  );

  allocator_checker chk (
    .clk, .rst, .in_valid, .in_stall, .req_type, .entity_id, .passport,
    .out_valid, .out_stall, .entity_index, .ok, .live_count, .mismatches, .pending
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send(logic [REQ_WIDTH-1:0] req, logic [IW-1:0] id, logic [PW-1:0] pp);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    entity_id <= id;
    passport <= pp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Most destroys should hit a live entry, otherwise the free list barely moves.
  function automatic logic [IW-1:0] pick_live_index();
    logic [IW-1:0] cand;
    for (int k = 0; k < 24; k++) begin
      cand = (k % 2 == 0) ? IW'($urandom_range(1, 255)) : IW'($urandom_range(1, NUM - 1));
      if (chk.is_live(cand)) return cand;
    end
    return IW'($urandom_range(1, NUM - 1));
  endfunction

  task automatic random_item();
    int unsigned   pick;
    int unsigned   shape;
    logic [IW-1:0] idx;
    logic [GW-1:0] g;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send(REQ_CREATE, IW'($urandom), PW'($urandom));
    end else if (pick < 65) begin
      idx = ($urandom_range(9) < 8) ? pick_live_index() : IW'($urandom);
      send(REQ_DESTROY, idx, PW'($urandom));
    end else if (pick < 95) begin
      idx = ($urandom_range(1) != 0) ? IW'($urandom_range(0, 255)) : IW'($urandom);
      g = chk.generation_of(idx);
      shape = $urandom_range(9);
      if (shape < 7)
        send(REQ_CHECK, IW'($urandom), {g, idx});
      else if (shape < 9)
        send(REQ_CHECK, IW'($urandom), {g + GW'(1), idx});
      else
        send(REQ_CHECK, IW'($urandom), PW'($urandom));
    end else begin
      send(REQ_UNKNOWN, IW'($urandom), PW'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_CREATE;
    entity_id <= '0;
    passport <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: null passport, extremes, null and free destroys, unknown request.
    send(REQ_CHECK, '0, '0);
    send(REQ_CHECK, '1, '1);
    send(REQ_DESTROY, '0, '0);
    send(REQ_DESTROY, '1, '0);
    send(REQ_UNKNOWN, '1, '1);
    send(REQ_CREATE, '0, '0);
    send(REQ_CREATE, '1, '1);
    send(REQ_CREATE, '0, '0);
    send(REQ_DESTROY, 12'd2, '0);
    send(REQ_DESTROY, 12'd2, '0);
    send(REQ_CHECK, '0, {8'd1, 12'd2});
    send(REQ_CHECK, '0, {8'd0, 12'd2});
    send(REQ_CREATE, '0, '0);
    send(REQ_DESTROY, 12'd1, '0);
    send(REQ_DESTROY, 12'd3, '0);
    send(REQ_CREATE, '0, '0);
    send(REQ_CREATE, '0, '0);
    send(REQ_CHECK, '0, {8'd1, 12'd1});

    // Recycle one index until its generation wraps around.
    for (int i = 0; i < 260; i++) begin
      send(REQ_DESTROY, 12'd2, PW'($urandom));
      send(REQ_CREATE, IW'($urandom), PW'($urandom));
      if (i % 16 == 15)
        send(REQ_CHECK, IW'($urandom), {chk.generation_of(12'd2), 12'd2});
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      repeat (235) random_item();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/gha_pkg.sv
hdl/generational_handle_allocator.sv
bench/allocator_checker.sv
bench/tb_generational_handle_allocator.sv
